### design/sbd_pkg.sv
// Shared types, constants and tables for the SPI baud divider search.
`default_nettype none
package sbd_pkg;

  localparam int unsigned ClkW   = 31;               // source clock register
  localparam int unsigned WantW  = 32;               // requested rate
  localparam int unsigned NumW   = ClkW + 1;         // clock times doubler
  localparam int unsigned DenW   = 18;               // 7 * 32768 fits
  localparam int unsigned RateW  = 30;               // every quotient fits
  localparam int unsigned StepW  = $clog2(NumW);     // divider step counter
  localparam int unsigned ComboW = 7;                // 4 x 16 x 2 combinations

  localparam logic [ClkW-1:0] ClkReset = ClkW'(50000000);

  localparam logic [2:0]  Prescale [4]  = '{3'd2, 3'd3, 3'd5, 3'd7};
  localparam logic [15:0] Scale    [16] = '{
    16'd2,    16'd4,    16'd6,    16'd8,    16'd16,   16'd32,   16'd64,    16'd128,
    16'd256,  16'd512,  16'd1024, 16'd2048, 16'd4096, 16'd8192, 16'd16384, 16'd32768
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EVAL,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RateW-1:0] quot;
  } div_rsp_t;

  // Divisor of one prescaler/scaler pair.
  function automatic logic [DenW-1:0] den_of(logic [1:0] p, logic [3:0] s);
    logic [DenW:0] prod;
    prod = (DenW+1)'(Prescale[p]) * (DenW+1)'(Scale[s]);
    return prod[DenW-1:0];
  endfunction

endpackage
`default_nettype wire

### design/sbd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module sbd_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sbd_pkg::div_req_t req_i,
  output sbd_pkg::div_rsp_t      rsp_o
);

  localparam logic [sbd_pkg::StepW-1:0] LastStep = sbd_pkg::StepW'(sbd_pkg::NumW - 1);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [sbd_pkg::StepW-1:0]   cnt_q, cnt_d;
  logic [sbd_pkg::DenW-1:0]    rem_q;
  logic [sbd_pkg::NumW-1:0]    quot_q;
  logic [sbd_pkg::DenW-1:0]    den_q;
  logic [sbd_pkg::DenW:0]      shifted;
  logic                        ge;
  logic                        load;

  assign load    = req_i.start && !run_q;
  assign shifted = {rem_q, quot_q[sbd_pkg::NumW-1]};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    done_d = run_q && (cnt_q == LastStep);
    if (load) begin
      run_d = 1'b1;
      cnt_d = '0;
    end else if (run_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // numerator shifts out of quot_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= '0;
      quot_q <= req_i.num;
      den_q  <= req_i.den;
    end else if (run_q) begin
      rem_q  <= ge ? sbd_pkg::DenW'(shifted - {1'b0, den_q}) : shifted[sbd_pkg::DenW-1:0];
      quot_q <= {quot_q[sbd_pkg::NumW-2:0], ge};
    end
  end

  assign rsp_o = '{done: done_q, quot: quot_q[sbd_pkg::RateW-1:0]};

endmodule
`default_nettype wire

### design/spi_baud_divider_search.sv
// Top level of the SPI baud divider search.
//
// Usage
//   Configuration: APB-style slave, register 0 (byte address 0) holds the
//   31-bit source clock in Hz, reset value 50 MHz. pready is tied high; write
//   it only while busy is low.
//   Command: a transfer is taken at a rising edge with start high and busy
//   low; requested_baud_i is sampled there. busy then stays high until the
//   result has been shown.
//   Result: done_o is high for exactly one cycle with the chosen prescaler
//   index, scaler index, doubler, achieved rate and no_match_o. The receiver
//   cannot stall; the result must be taken in that cycle.
//   Search: all 128 combinations go through one shared restoring divider,
//   one quotient bit per cycle. Each combination passes through launch, 32
//   divide steps, quotient handover and compare, one after the other. A new
//   command is taken only once busy has dropped after done_o.
//   Reset: asynchronous, active low; returns to idle and reloads the clock
//   register with its default.
`default_nettype none
module spi_baud_divider_search (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB-style configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // command
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sbd_pkg::WantW-1:0]   requested_baud_i,
  // result
  output logic                             done_o,
  output logic [1:0]                       prescaler_index_o,
  output logic [3:0]                       scaler_index_o,
  output logic [1:0]                       doubler_o,
  output logic [sbd_pkg::RateW-1:0]        achieved_baud_o,
  output logic                             no_match_o
);

  sbd_pkg::state_e            state_q, state_d;
  logic [sbd_pkg::ClkW-1:0]   clk_hz_q;
  logic [sbd_pkg::WantW-1:0]  want_q;
  logic [sbd_pkg::ComboW-1:0] combo_q;
  logic [sbd_pkg::RateW-1:0]  rate_q;
  logic                       have_q;
  logic [sbd_pkg::WantW-1:0]  best_diff_q;
  logic [1:0]                 best_p_q;
  logic [3:0]                 best_s_q;
  logic [1:0]                 best_d_q;
  logic [sbd_pkg::RateW-1:0]  best_rate_q;

  sbd_pkg::div_req_t          div_req;
  sbd_pkg::div_rsp_t          div_rsp;
  logic                       div_start;
  logic [sbd_pkg::NumW-1:0]   div_num;

  logic                       accept;
  logic                       cfg_wr;
  logic                       last_combo;
  logic [sbd_pkg::WantW-1:0]  rate_ext;
  logic [sbd_pkg::WantW-1:0]  diff;
  logic                       take;

  // combo_q = {prescaler, scaler, doubler-1}: doubler innermost, as the search order asks
  assign accept     = start && !busy;
  assign cfg_wr     = psel && penable && pwrite && pready && !paddr[2];
  assign last_combo = &combo_q;

  assign rate_ext = {{(sbd_pkg::WantW - sbd_pkg::RateW){1'b0}}, rate_q};
  assign diff     = want_q - rate_ext;
  assign take     = (rate_ext <= want_q) && (!have_q || diff < best_diff_q);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= sbd_pkg::ClkReset;
    end else if (cfg_wr) begin
      clk_hz_q <= pwdata[sbd_pkg::ClkW-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {1'b0, clk_hz_q};
  assign pready = 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbd_pkg::ST_IDLE:   if (accept) state_d = sbd_pkg::ST_START;
      sbd_pkg::ST_START:  state_d = sbd_pkg::ST_WAIT;
      sbd_pkg::ST_WAIT:   if (div_rsp.done) state_d = sbd_pkg::ST_EVAL;
      sbd_pkg::ST_EVAL:   state_d = last_combo ? sbd_pkg::ST_REPORT : sbd_pkg::ST_START;
      sbd_pkg::ST_REPORT: state_d = sbd_pkg::ST_IDLE;
      default:            state_d = sbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    done_o    = 1'b0;
    div_start = 1'b0;
    case (state_q)
      sbd_pkg::ST_IDLE:   busy = 1'b0;
      sbd_pkg::ST_START:  div_start = 1'b1;
      sbd_pkg::ST_REPORT: done_o = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

  // numerator is the clock, doubled when the doubler bit is set
  assign div_num = combo_q[0] ? {clk_hz_q, 1'b0} : {1'b0, clk_hz_q};
  assign div_req = '{start: div_start,
                     num:   div_num,
                     den:   sbd_pkg::den_of(combo_q[6:5], combo_q[4:1])};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbd_pkg::ST_IDLE;
      combo_q <= '0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        combo_q <= '0;
        have_q  <= 1'b0;
      end else if (state_q == sbd_pkg::ST_EVAL) begin
        combo_q <= combo_q + 1'b1;
        if (take) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      want_q      <= requested_baud_i;
      best_diff_q <= '0;
      best_p_q    <= '0;
      best_s_q    <= '0;
      best_d_q    <= 2'd1;
      best_rate_q <= '0;
    end else begin
      if ((state_q == sbd_pkg::ST_WAIT) && div_rsp.done) begin
        rate_q <= div_rsp.quot;
      end
      if ((state_q == sbd_pkg::ST_EVAL) && take) begin
        best_diff_q <= diff;
        best_p_q    <= combo_q[6:5];
        best_s_q    <= combo_q[4:1];
        best_d_q    <= combo_q[0] ? 2'd2 : 2'd1;
        best_rate_q <= rate_q;
      end
    end
  end

  sbd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result fields hold the best candidate; sampled only with done_o
  assign prescaler_index_o = best_p_q;
  assign scaler_index_o    = best_s_q;
  assign doubler_o         = best_d_q;
  assign achieved_baud_o   = best_rate_q;
  assign no_match_o        = !have_q;

endmodule
`default_nettype wire

### design/sbd_checker.sv
// Port-level checks for the SPI baud divider search, bound to the top level.
`default_nettype none
module sbd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        done_o,
  input  wire logic [1:0]  prescaler_index_o,
  input  wire logic [3:0]  scaler_index_o,
  input  wire logic [1:0]  doubler_o,
  input  wire logic [29:0] achieved_baud_o,
  input  wire logic        no_match_o
);

  // a command transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // result only while busy, and busy drops right after it
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy ##1 (!busy && !done_o)))
    else $error("result strobe outside busy window or not single");

  // no new result without a new command
  a_done_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !done_o)
    else $error("result strobe without command");

  a_no_match_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_match_o) |->
      (prescaler_index_o == 2'd0 && scaler_index_o == 4'd0 &&
       doubler_o == 2'd1 && achieved_baud_o == 30'd0))
    else $error("no-match result fields wrong");

  a_doubler_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (doubler_o == 2'd1 || doubler_o == 2'd2))
    else $error("doubler out of range");

endmodule

bind spi_baud_divider_search sbd_checker u_sbd_checker (.*);
`default_nettype wire
